// ===== src/dh_forward_kinematics_chain_defines.svh =====
// Assertion macros shared by the forward kinematics chain RTL.
`ifndef DH_FORWARD_KINEMATICS_CHAIN_DEFINES_SVH
`define DH_FORWARD_KINEMATICS_CHAIN_DEFINES_SVH
`ifndef ASSERT_OFF
`define DHFK_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DHFK_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DHFK_ASSERT(label, clk, rst, prop, msg)
`define DHFK_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== src/dhfk_pkg.sv =====
// Package with types, constants and helper functions of the kinematics chain.
`default_nettype none
package dhfk_pkg;
  localparam int FracBitsDefault = 16;
  localparam int CordicStepsDefault = 16;
  localparam int WorkBits = 30;
  localparam int AtanCount = 30;
  localparam logic signed [35:0] PiW = 36'sd3373259426;
  localparam logic signed [35:0] HalfPiW = 36'sd1686629713;
  localparam logic signed [35:0] TwoPiW = 36'sd6746518852;
  localparam logic signed [35:0] GainW = 36'sd652032874;

  localparam logic [1:0] KIND_REVOLUTE = 2'd0;
  localparam logic [1:0] KIND_PRISMATIC = 2'd1;

  typedef struct packed {
    logic        start_chain;
    logic [1:0]  joint_kind;
    logic signed [31:0] joint_pos;
    logic signed [31:0] link_theta;
    logic signed [31:0] link_offset;
    logic signed [31:0] link_length;
    logic signed [31:0] link_twist;
  } dhfk_in_t;

  typedef struct packed {
    logic signed [31:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
    logic signed [31:0] pos_x, pos_y, pos_z;
  } dhfk_out_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic       load;
    logic       red_step;
    logic       cordic_init;
    logic       cordic_step;
    logic       cordic_done;
    logic       mac_en;
    logic       mac_clear;
    logic [3:0] mac_elem;
    logic [1:0] mac_term;
    logic       link_en;
    logic [2:0] link_idx;
  } dhfk_cmd_t;

  // Number of compare and subtract steps that bring a scaled angle below 2 pi.
  function automatic int red_steps(input int frac_bits);
    return (WorkBits - frac_bits > 1) ? WorkBits - frac_bits : 1;
  endfunction

  function automatic logic signed [35:0] atan_w(input logic [4:0] i);
    logic signed [35:0] v;
    unique case (i)
      5'd0: v = 36'sh03243F6A8;  5'd1: v = 36'sh01DAC6705;
      5'd2: v = 36'sh00FADBAFC;  5'd3: v = 36'sh007F56EA6;
      5'd4: v = 36'sh003FEAB76;  5'd5: v = 36'sh001FFD55B;
      5'd6: v = 36'sh000FFFAAA;  5'd7: v = 36'sh0007FFF55;
      5'd8: v = 36'sh0003FFFEA;  5'd9: v = 36'sh0001FFFFD;
      5'd10: v = 36'sh0000FFFFF; 5'd11: v = 36'sh00007FFFF;
      5'd12: v = 36'sh00003FFFF; 5'd13: v = 36'sh00001FFFF;
      5'd14: v = 36'sh00000FFFF; 5'd15: v = 36'sh000007FFF;
      5'd16: v = 36'sh000003FFF; 5'd17: v = 36'sh000001FFF;
      5'd18: v = 36'sh000000FFF; 5'd19: v = 36'sh0000007FF;
      5'd20: v = 36'sh0000003FF; 5'd21: v = 36'sh0000001FF;
      5'd22: v = 36'sh0000000FF; 5'd23: v = 36'sh00000007F;
      5'd24: v = 36'sh00000003F; 5'd25: v = 36'sh00000001F;
      5'd26: v = 36'sh00000000F; 5'd27: v = 36'sh000000008;
      5'd28: v = 36'sh000000004; 5'd29: v = 36'sh000000002;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== src/dhfk_ctrl.sv =====
// Controller state machine sequencing angle reduction, CORDIC, link build and matrix product.
`default_nettype none
`include "dh_forward_kinematics_chain_defines.svh"
module dhfk_ctrl #(
  parameter int FRAC_BITS = dhfk_pkg::FracBitsDefault,
  parameter int CORDIC_STEPS = dhfk_pkg::CordicStepsDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  output dhfk_pkg::dhfk_cmd_t cmd
);
  import dhfk_pkg::*;
  localparam int RedSteps = red_steps(FRAC_BITS);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INIT = 3'd1;
  localparam logic [2:0] S_CORD = 3'd2;
  localparam logic [2:0] S_LINK = 3'd3;
  localparam logic [2:0] S_MAC = 3'd4;
  localparam logic [2:0] S_OUT = 3'd5;
  localparam logic [2:0] S_RED = 3'd6;

  logic [2:0] state, state_next;
  logic [4:0] cnt, cnt_next;
  logic [3:0] elem, elem_next;
  logic [1:0] term, term_next;

  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cnt_next = cnt;
    elem_next = elem;
    term_next = term;
    cmd = '0;
    cmd.mac_elem = elem;
    cmd.mac_term = term;
    cmd.link_idx = cnt[2:0];
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          cnt_next = '0;
          state_next = S_RED;
        end
      end
      S_RED: begin
        cmd.red_step = 1'b1;
        cnt_next = cnt + 5'd1;
        if (cnt == 5'(RedSteps - 1)) state_next = S_INIT;
      end
      S_INIT: begin
        cmd.cordic_init = 1'b1;
        cnt_next = '0;
        state_next = S_CORD;
      end
      S_CORD: begin
        cmd.cordic_step = 1'b1;
        cnt_next = cnt + 5'd1;
        if (cnt == 5'(CORDIC_STEPS - 1)) begin
          cnt_next = '0;
          state_next = S_LINK;
        end
      end
      S_LINK: begin
        if (cnt == 5'd0) cmd.cordic_done = 1'b1;
        else begin
          cmd.link_en = 1'b1;
          cmd.link_idx = 3'(cnt - 5'd1);
        end
        cnt_next = cnt + 5'd1;
        if (cnt == 5'd6) begin
          elem_next = '0;
          term_next = '0;
          state_next = S_MAC;
        end
      end
      S_MAC: begin
        cmd.mac_en = 1'b1;
        cmd.mac_clear = (term == 2'd0);
        if (term == 2'd2) begin
          term_next = '0;
          elem_next = elem + 4'd1;
          if (elem == 4'd11) state_next = S_OUT;
        end else begin
          term_next = term + 2'd1;
        end
      end
      S_OUT: begin
        elem_next = '0;
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      elem <= '0;
      term <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      elem <= elem_next;
      term <= term_next;
    end
  end

  `DHFK_ASSERT(a_no_accept_busy, clk, rst, (state != S_IDLE) |-> in_stall, "accept while busy")
  `DHFK_ASSERT(a_out_after_mac, clk, rst, $rose(out_valid) |-> $past(state) == S_MAC, "bad output entry")
  `DHFK_ASSERT(a_out_hold, clk, rst, (out_valid && out_stall) |=> out_valid, "result dropped")
endmodule
`default_nettype wire

// ===== src/dhfk_datapath.sv =====
// Datapath: angle reduction, dual CORDIC, link matrix builder and shared multiply-add.
`default_nettype none
module dhfk_datapath #(
  parameter int FRAC_BITS = dhfk_pkg::FracBitsDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire dhfk_pkg::dhfk_in_t  in_item,
  input  wire dhfk_pkg::dhfk_cmd_t cmd,
  output dhfk_pkg::dhfk_out_t      out_item
);
  import dhfk_pkg::*;
  localparam int Sh = WorkBits - FRAC_BITS;
  localparam int ZW = Sh + 36;
  localparam int RedK = red_steps(FRAC_BITS) - 1;
  localparam logic signed [ZW-1:0] Span0 = ZW'(TwoPiW) <<< RedK;
  localparam logic signed [31:0] One = 32'sd1 <<< FRAC_BITS;

  dhfk_in_t item;
  logic signed [31:0] pose [12];
  logic signed [31:0] next [12];
  logic signed [31:0] link [12];
  // Angle reduction registers for theta and alpha, with the shared modulus.
  logic signed [ZW-1:0] tr, ar, span;
  // CORDIC registers for theta (t) and alpha (a).
  logic signed [35:0] tx, ty, tz, ax, ay, az;
  logic tflip, aflip;
  logic [4:0] step;
  logic signed [31:0] st, ct, sa, ca;
  logic signed [65:0] acc;

  // Scale an angle to the working format and make it non-negative by adding
  // a multiple of 2 pi that covers the whole input range.
  function automatic logic signed [ZW-1:0] lift(input logic signed [31:0] ang);
    logic signed [ZW-1:0] z;
    z = ZW'(ang) <<< Sh;
    if (ang < 0) z = z + Span0;
    return z;
  endfunction

  // Move a reduced angle in [0, 2 pi) to [-pi/2, pi/2] plus a flip flag.
  function automatic logic [36:0] fold(input logic signed [ZW-1:0] r);
    logic signed [ZW-1:0] z;
    logic flip;
    z = r;
    if (z >= ZW'(PiW)) z = z - ZW'(TwoPiW);
    flip = 1'b0;
    if (z > ZW'(HalfPiW)) begin z = z - ZW'(PiW); flip = 1'b1; end
    else if (z < -ZW'(HalfPiW)) begin z = z + ZW'(PiW); flip = 1'b1; end
    return {flip, 36'(z)};
  endfunction

  function automatic logic signed [31:0] rnd(input logic signed [35:0] v);
    logic signed [65:0] w;
    if (Sh == 0) w = 66'(v);
    else w = (66'(v) + (66'sd1 <<< (Sh - 1))) >>> Sh;
    return sat32(w);
  endfunction

  logic [36:0] rt, ra;
  logic signed [31:0] theta_in;
  always_comb begin
    theta_in = (in_item.joint_kind == KIND_REVOLUTE) ? in_item.joint_pos
                                                      : in_item.link_theta;
    rt = fold(tr);
    ra = fold(ar);
  end

  // Angle reduction: one compare and subtract of a halving multiple of 2 pi
  // per cycle, both angles in parallel.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_item;
      tr <= lift(theta_in);
      ar <= lift(in_item.link_twist);
      span <= Span0;
    end else if (cmd.red_step) begin
      if (tr >= span) tr <= tr - span;
      if (ar >= span) ar <= ar - span;
      span <= span >>> 1;
    end
  end

  // CORDIC rotation; both angles advance in the same iteration.
  always_ff @(posedge clk) begin
    if (cmd.cordic_init) begin
      tx <= GainW; ty <= '0; tz <= rt[35:0]; tflip <= rt[36];
      ax <= GainW; ay <= '0; az <= ra[35:0]; aflip <= ra[36];
      step <= '0;
    end else if (cmd.cordic_step) begin
      step <= step + 5'd1;
      if (tz >= 0) begin
        tx <= tx - (ty >>> step); ty <= ty + (tx >>> step); tz <= tz - atan_w(step);
      end else begin
        tx <= tx + (ty >>> step); ty <= ty - (tx >>> step); tz <= tz + atan_w(step);
      end
      if (az >= 0) begin
        ax <= ax - (ay >>> step); ay <= ay + (ax >>> step); az <= az - atan_w(step);
      end else begin
        ax <= ax + (ay >>> step); ay <= ay - (ax >>> step); az <= az + atan_w(step);
      end
    end
    if (cmd.cordic_done) begin
      ct <= rnd(tflip ? -tx : tx); st <= rnd(tflip ? -ty : ty);
      ca <= rnd(aflip ? -ax : ax); sa <= rnd(aflip ? -ay : ay);
    end
  end

  function automatic logic signed [31:0] fxmul(input logic signed [31:0] x,
                                             input logic signed [31:0] y);
    logic signed [65:0] p;
    p = (66'(x) * 66'(y) + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return sat32(p);
  endfunction

  // Link build: one product per cycle through a single multiplier.
  logic signed [31:0] lprod, mx, my;
  always_comb begin
    unique case (cmd.link_idx)
      3'd0: begin mx = st; my = ca; end
      3'd1: begin mx = st; my = sa; end
      3'd2: begin mx = item.link_length; my = ct; end
      3'd3: begin mx = ct; my = ca; end
      3'd4: begin mx = ct; my = sa; end
      default: begin mx = item.link_length; my = st; end
    endcase
    lprod = fxmul(mx, my);
  end

  always_ff @(posedge clk) begin
    if (cmd.link_en) begin
      unique case (cmd.link_idx)
        3'd0: link[1] <= sat32(-66'(lprod));
        3'd1: link[2] <= lprod;
        3'd2: link[3] <= lprod;
        3'd3: link[5] <= lprod;
        3'd4: link[6] <= sat32(-66'(lprod));
        default: link[7] <= lprod;
      endcase
      link[0] <= ct; link[4] <= st; link[8] <= '0;
      link[9] <= sa; link[10] <= ca;
      link[11] <= (item.joint_kind == KIND_PRISMATIC) ? item.joint_pos : item.link_offset;
    end
  end

  // Effective previous pose: identity when start_chain is set.
  logic signed [31:0] pa, lb;
  logic [1:0] row;
  logic [1:0] col;
  logic [3:0] pidx, lidx;
  always_comb begin
    row = 2'(cmd.mac_elem >> 2);
    col = cmd.mac_elem[1:0];
    pidx = {row, cmd.mac_term};
    lidx = {cmd.mac_term, col};
    if (item.start_chain) pa = (row == cmd.mac_term) ? One : '0;
    else pa = pose[pidx];
    lb = link[lidx];
  end

  // Multiply-add; the old translation enters once, with the first term.
  logic signed [31:0] prod;
  logic signed [65:0] acc_next;
  logic signed [31:0] tpos;
  always_comb begin
    prod = fxmul(pa, lb);
    acc_next = (cmd.mac_clear ? 66'sd0 : acc) + 66'(prod);
    tpos = item.start_chain ? 32'sd0 : pose[{row, 2'd3}];
    if (col == 2'd3 && cmd.mac_clear) acc_next = acc_next + 66'(tpos);
  end

  always_ff @(posedge clk) begin
    if (cmd.mac_en) begin
      acc <= acc_next;
      if (cmd.mac_term == 2'd2) next[cmd.mac_elem] <= sat32(acc_next);
    end
  end

  // Pose register; the commit happens once the new pose is complete.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 12; k++) pose[k] <= (k == 0 || k == 5 || k == 10) ? One : '0;
    end else if (cmd.mac_en && cmd.mac_elem == 4'd11 && cmd.mac_term == 2'd2) begin
      for (int k = 0; k < 11; k++) pose[k] <= next[k];
      pose[11] <= sat32(acc_next);
    end
  end

  assign out_item = '{r00: pose[0], r01: pose[1], r02: pose[2],
                      r10: pose[4], r11: pose[5], r12: pose[6],
                      r20: pose[8], r21: pose[9], r22: pose[10],
                      pos_x: pose[3], pos_y: pose[7], pos_z: pose[11]};
endmodule
`default_nettype wire

// ===== src/dh_forward_kinematics_chain.sv =====
// Top level of the Denavit-Hartenberg forward kinematics chain.
// Each item passes through angle reduction (max(30 - FRAC_BITS, 1) steps), the
// CORDIC loop, the link build and the single multiply-add unit (36 products).
// A new item is accepted only once the previous result has left the output;
// in_stall is high while an item is in flight.
// Reset (rst, synchronous) loads the identity pose and idles the controller.
`default_nettype none
module dh_forward_kinematics_chain #(
  parameter int FRAC_BITS = dhfk_pkg::FracBitsDefault,
  parameter int CORDIC_STEPS = dhfk_pkg::CordicStepsDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire dhfk_pkg::dhfk_in_t in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output dhfk_pkg::dhfk_out_t out_data
);
  import dhfk_pkg::*;
  dhfk_cmd_t cmd;

  dhfk_ctrl #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .cmd
  );
  dhfk_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst, .in_item(in_data), .cmd, .out_item(out_data)
  );
endmodule
`default_nettype wire
